@@ hw/rtl/eeprom_job_controller_unit_assert.svh @@
// Assertion macros for the EEPROM job controller.
// Used inside modules that have clk and arst_n in scope.
`ifndef EEPROM_JOB_CONTROLLER_UNIT_ASSERT_SVH
`define EEPROM_JOB_CONTROLLER_UNIT_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define EJC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define EJC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ hw/rtl/ejc_pkg.sv @@
// Shared constants, codes and types of the EEPROM job controller.
// No dependencies; every other RTL file imports this package.
package ejc_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int JA_W        = ADDR_W + 1;
	localparam int CMP_W       = 17;
	localparam int BURST_MAX   = 32;
	localparam int RB_W        = 6;
	localparam int MR_W        = 2;
	localparam int CMD_W       = 2;
	localparam int FADDR_W     = 10;
	localparam int LEN_W       = 11;
	localparam int DATA_W      = 8;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 24;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [RB_W-1:0] RB_RESET = RB_W'(32);
	localparam logic [MR_W-1:0] MR_RESET = MR_W'(2);

	localparam logic REG_READ_BURST  = 1'b0;
	localparam logic REG_MAX_RETRIES = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_POLL  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_BUSY = 2'd1,
		ST_OK   = 2'd2,
		ST_FAIL = 2'd3
	} jstat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_READ,
		S_VER_RD,
		S_VER,
		S_PROG_RD,
		S_PROG,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [RB_W-1:0] read_burst;
		logic [MR_W-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FADDR_W-1:0] address;
		logic [LEN_W-1:0]   length;
		logic [DATA_W-1:0]  data_byte;
		logic               write_done;
		logic [DATA_W-1:0]  fault_mask;
	} item_t;

endpackage

@@ hw/rtl/eeprom_job_controller_unit.sv @@
// Top level of the EEPROM job controller: configuration registers, sequencer and store.
// Depends on ejc_pkg, ejc_cfg, ejc_seq, ejc_store and the assertion macro header.
//
// After reset the controller fills the store with 0xFF, one byte per cycle, and accepts
// no request until that pass is over; register writes are taken throughout. Each request
// is then taken in S_IDLE and decoded in S_DISPATCH. A read request delivers up to
// read_burst bytes (capped to 1..32), one per cycle while the downstream side takes them,
// through the store's single read port. A begin-write request reads the byte to compare,
// programs it if it differs and hands over one result; a poll that verifies a write reads
// the byte back and, on a match with bytes left, compares and programs the next one. Other
// requests hand over one result. A new request is taken while the previous result still
// waits downstream; a step that must hand over a result, or reuse the store's read register
// while an unread byte is still waiting, holds until the downstream side takes that result.
module eeprom_job_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// address[9:0], length[20:10], data_byte[28:21], write_done[29], fault_mask[37:30]
	input  logic [ejc_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[1:0]
	input  logic [ejc_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// accepted[0], status[2:1], read_data[10:3], current_address[20:11]
	output logic [ejc_pkg::M_TDATA_W-1:0]   m_tdata,
	// read_valid[0]
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ejc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ejc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ejc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import ejc_pkg::*;

	cfg_t              cfg;
	mem_req_t          mem_req;
	logic [DATA_W-1:0] rdata_s1;

	ejc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ejc_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.rdata_s1 (rdata_s1)
	);

	ejc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg      (cfg),
		.mem_req  (mem_req),
		.rdata_s1 (rdata_s1)
	);

`include "eeprom_job_controller_unit_assert.svh"

	`EJC_ASSERT_NEXT(a_one_request_at_a_time, s_tvalid && s_tready, !s_tready)
	`EJC_ASSERT_IMP(a_read_byte_status, m_tvalid && m_tuser[0], m_tdata[2:1] == ST_BUSY || m_tdata[2:1] == ST_OK)
	`EJC_ASSERT_IMP(a_single_result_is_last, m_tvalid && !m_tuser[0], m_tlast)

endmodule

@@ hw/rtl/ejc_cfg.sv @@
// Configuration registers of the EEPROM job controller behind an APB-style port.
// Depends on ejc_pkg.
module ejc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ejc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ejc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ejc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output ejc_pkg::cfg_t                    cfg
);
	import ejc_pkg::*;

	logic            wr_en;
	logic            reg_sel;
	logic [RB_W-1:0] rb_q;
	logic [MR_W-1:0] mr_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q <= RB_RESET;
			mr_q <= MR_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_READ_BURST:  rb_q <= pwdata[RB_W-1:0];
				REG_MAX_RETRIES: mr_q <= pwdata[MR_W-1:0];
				default:         rb_q <= rb_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_READ_BURST:  prdata = {{(APB_DATA_W-RB_W){1'b0}}, rb_q};
			REG_MAX_RETRIES: prdata = {{(APB_DATA_W-MR_W){1'b0}}, mr_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.read_burst  = rb_q;
	assign cfg.max_retries = mr_q;

endmodule

@@ hw/rtl/ejc_store.sv @@
// Byte store of the EEPROM job controller: one write port, one registered read port.
// Depends on ejc_pkg.
module ejc_store (
	input  logic                          clk,
	input  ejc_pkg::mem_req_t             req,
	output logic [ejc_pkg::DATA_W-1:0]    rdata_s1
);
	import ejc_pkg::*;

	logic [DATA_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_s1 <= mem[req.raddr];
		end
	end

endmodule

@@ hw/rtl/ejc_seq.sv @@
// Job sequencer of the EEPROM job controller: request decode, read bursts,
// compare, program and verify steps, and the result register. Depends on ejc_pkg.
module ejc_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ejc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ejc_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ejc_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast,
	input  ejc_pkg::cfg_t                   cfg,
	output ejc_pkg::mem_req_t               mem_req,
	input  logic [ejc_pkg::DATA_W-1:0]      rdata_s1
);
	import ejc_pkg::*;

	function automatic logic [FADDR_W-1:0] to_faddr(input logic [JA_W-1:0] a);
		logic [JA_W+FADDR_W-1:0] w;
		w = {{FADDR_W{1'b0}}, a};
		return w[FADDR_W-1:0];
	endfunction

	function automatic logic [JA_W-1:0] from_faddr(input logic [FADDR_W-1:0] a);
		logic [JA_W+FADDR_W-1:0] w;
		w = {{JA_W{1'b0}}, a};
		return w[JA_W-1:0];
	endfunction

	seq_state_t        state_q, state_d;
	item_t             item_q;
	op_t               op_q, op_d;
	jstat_t            status_q, status_d;
	logic [JA_W-1:0]   jaddr_q, jaddr_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [MR_W-1:0]   retry_q, retry_d;
	logic [DATA_W-1:0] pend_q, pend_d;
	logic              skip_q, skip_d;
	logic              acc_q, acc_d;
	logic [RB_W-1:0]   burst_q, burst_d;
	logic [ADDR_W-1:0] clr_q, clr_d;

	logic               ov_q;
	logic               oacc_q;
	jstat_t             ost_q;
	logic               orv_q;
	logic [FADDR_W-1:0] oaddr_q;
	logic               olast_q;

	logic               out_load;
	logic               o_acc;
	jstat_t             o_st;
	logic               o_rv;
	logic [FADDR_W-1:0] o_addr;
	logic               o_last;

	logic              accept;
	logic              slot_free;
	logic              rd_free;
	logic              req_ok;
	logic [CMP_W-1:0]  req_end;
	logic [RB_W-1:0]   eff_burst;
	logic [JA_W-1:0]   jaddr_inc;
	logic [LEN_W-1:0]  left_dec;
	logic [ADDR_W-1:0] cur_idx;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !ov_q || m_tready;
	// The read register may be reused unless it still holds a byte awaiting delivery.
	assign rd_free   = !(ov_q && orv_q) || m_tready;
	assign req_end   = CMP_W'(item_q.address) + CMP_W'(item_q.length);
	assign req_ok    = (status_q != ST_BUSY) && (item_q.length != '0) &&
		(CMP_W'(item_q.address) < CMP_W'(STORE_DEPTH)) &&
		(req_end <= CMP_W'(STORE_DEPTH));
	assign eff_burst = (cfg.read_burst == '0) ? RB_W'(1) :
		(cfg.read_burst > RB_W'(BURST_MAX)) ? RB_W'(BURST_MAX) : cfg.read_burst;
	assign jaddr_inc = jaddr_q + JA_W'(1);
	assign left_dec  = left_q - LEN_W'(1);
	assign cur_idx   = jaddr_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			op_q     <= OP_NONE;
			status_q <= ST_IDLE;
			jaddr_q  <= '0;
			left_q   <= '0;
			retry_q  <= '0;
			pend_q   <= '0;
			skip_q   <= 1'b0;
			acc_q    <= 1'b0;
			burst_q  <= '0;
			clr_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			status_q <= status_d;
			jaddr_q  <= jaddr_d;
			left_q   <= left_d;
			retry_q  <= retry_d;
			pend_q   <= pend_d;
			skip_q   <= skip_d;
			acc_q    <= acc_d;
			burst_q  <= burst_d;
			clr_q    <= clr_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd        <= s_tuser;
			item_q.address    <= s_tdata[9:0];
			item_q.length     <= s_tdata[20:10];
			item_q.data_byte  <= s_tdata[28:21];
			item_q.write_done <= s_tdata[29];
			item_q.fault_mask <= s_tdata[37:30];
		end
		if (out_load) begin
			oacc_q  <= o_acc;
			ost_q   <= o_st;
			orv_q   <= o_rv;
			oaddr_q <= o_addr;
			olast_q <= o_last;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		status_d = status_q;
		jaddr_d  = jaddr_q;
		left_d   = left_q;
		retry_d  = retry_q;
		pend_d   = pend_q;
		skip_d   = skip_q;
		acc_d    = acc_q;
		burst_d  = burst_q;
		clr_d    = clr_q;
		mem_req  = '0;
		out_load = 1'b0;
		o_acc    = acc_q;
		o_st     = status_q;
		o_rv     = 1'b0;
		o_addr   = to_faddr(jaddr_q);
		o_last   = 1'b1;

		unique case (state_q)
			S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '1;
				clr_d         = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				acc_d   = 1'b0;
				burst_d = eff_burst;
				if (item_q.cmd == CMD_READ || item_q.cmd == CMD_WRITE) begin
					if (req_ok) begin
						jaddr_d  = from_faddr(item_q.address);
						left_d   = item_q.length;
						status_d = ST_BUSY;
						acc_d    = 1'b1;
						if (item_q.cmd == CMD_READ) begin
							op_d    = OP_READ;
							state_d = S_READ;
						end else begin
							op_d    = OP_WRITE;
							retry_d = '0;
							pend_d  = item_q.data_byte;
							state_d = S_PROG_RD;
						end
					end else begin
						state_d = S_EMIT;
					end
				end else if (item_q.cmd == CMD_POLL && op_q == OP_READ) begin
					state_d = S_READ;
				end else if (item_q.cmd == CMD_POLL && op_q == OP_WRITE &&
						(item_q.write_done || skip_q)) begin
					skip_d  = 1'b0;
					state_d = S_VER_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_READ: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (left_q != '0) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = cur_idx;
						o_rv          = 1'b1;
						o_addr        = to_faddr(jaddr_inc);
						o_last        = (left_q == LEN_W'(1)) || (burst_q == RB_W'(1));
						jaddr_d       = jaddr_inc;
						left_d        = left_dec;
						burst_d       = burst_q - RB_W'(1);
						if (left_q == LEN_W'(1)) begin
							status_d = ST_OK;
							op_d     = OP_NONE;
							o_st     = ST_OK;
						end
						if (o_last) begin
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_VER_RD: begin
				if (rd_free) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = cur_idx;
					state_d       = S_VER;
				end
			end
			S_VER: begin
				if (rdata_s1 == pend_q) begin
					retry_d = '0;
					jaddr_d = jaddr_inc;
					left_d  = left_dec;
					if (left_dec != '0) begin
						pend_d  = item_q.data_byte;
						state_d = S_PROG_RD;
					end else begin
						status_d = ST_OK;
						op_d     = OP_NONE;
						state_d  = S_EMIT;
					end
				end else if (retry_q < cfg.max_retries) begin
					retry_d       = retry_q + MR_W'(1);
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_idx;
					mem_req.wdata = pend_q ^ item_q.fault_mask;
					skip_d        = 1'b0;
					state_d       = S_EMIT;
				end else begin
					status_d = ST_FAIL;
					op_d     = OP_NONE;
					state_d  = S_EMIT;
				end
			end
			S_PROG_RD: begin
				if (rd_free) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = cur_idx;
					state_d       = S_PROG;
				end
			end
			S_PROG: begin
				if (rdata_s1 != pend_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cur_idx;
					mem_req.wdata = pend_q ^ item_q.fault_mask;
					skip_d        = 1'b0;
				end else begin
					skip_d = 1'b1;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid   = ov_q;
	assign m_tdata    = {3'b000, oaddr_q, (orv_q ? rdata_s1 : {DATA_W{1'b0}}), ost_q, oacc_q};
	assign m_tuser[0] = orv_q;
	assign m_tlast    = olast_q;

endmodule
